/* hdl/cdd_pkg.sv */
// Shared types, constants and calendar helpers for the date-time difference block.
package cdd_pkg;

  localparam int YEAR_SPAN = 1024;
  localparam int YR_W      = $clog2(YEAR_SPAN);
  localparam int ACC_W     = 44;
  localparam int DIFF_W    = 36;
  localparam int LIM_W     = 10;
  localparam int IN_YR_W   = 10;

  localparam logic signed [ACC_W-1:0] DIFF_MAX  = ACC_W'(64'sd34359738367);
  localparam logic signed [ACC_W-1:0] DIFF_MIN  = -DIFF_MAX;
  localparam logic [8:0]              DAYS_YEAR = 9'd365;
  // 1900 mod 400
  localparam logic [8:0]              BASE_MOD400 = 9'd300;

  typedef enum logic [2:0] {
    UNIT_YEAR   = 3'd0,
    UNIT_MONTH  = 3'd1,
    UNIT_DAY    = 3'd2,
    UNIT_HOUR   = 3'd3,
    UNIT_MINUTE = 3'd4,
    UNIT_SECOND = 3'd5
  } unit_e;

  typedef enum logic [1:0] {
    CFG_UNIT    = 2'd0,
    CFG_MIN_LIM = 2'd1,
    CFG_SEC_LIM = 2'd2
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_YEARS,
    ST_DOY_HI,
    ST_DAY_HI,
    ST_DOY_LO,
    ST_DAY_LO,
    ST_YY,
    ST_MUL12,
    ST_ADD_MO,
    ST_SUB_MO,
    ST_MUL24,
    ST_ADD_HR,
    ST_SUB_HR,
    ST_MUL60_MI,
    ST_ADD_MI,
    ST_SUB_MI,
    ST_MUL60_SE,
    ST_ADD_SE,
    ST_SUB_SE,
    ST_NEG,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic init;
    logic step;
  } yc_ctrl_t;

  function automatic logic [YR_W-1:0] clamp_year(input logic [IN_YR_W-1:0] y);
    if (int'(y) >= YEAR_SPAN) begin
      return YR_W'(YEAR_SPAN - 1);
    end
    return YR_W'(y);
  endfunction

  // Days before the first of the month; months past December count as December.
  function automatic logic [8:0] month_start(input logic [3:0] m, input logic leap);
    logic [8:0] d;
    case (m)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      default: d = 9'd334;
    endcase
    if (m >= 4'd2 && leap) begin
      d = d + 9'd1;
    end
    return d;
  endfunction

endpackage

/* hdl/cdd_if.sv */
// Request and response channel interfaces of the date-time difference block.
interface cdd_in_if;
  logic       valid;
  logic       ready;
  logic [9:0] later_year;
  logic [3:0] later_month;
  logic [4:0] later_day;
  logic [4:0] later_hour;
  logic [5:0] later_minute;
  logic [5:0] later_second;
  logic [9:0] earlier_year;
  logic [3:0] earlier_month;
  logic [4:0] earlier_day;
  logic [4:0] earlier_hour;
  logic [5:0] earlier_minute;
  logic [5:0] earlier_second;

  modport source (
    output valid, later_year, later_month, later_day, later_hour, later_minute,
           later_second, earlier_year, earlier_month, earlier_day, earlier_hour,
           earlier_minute, earlier_second,
    input  ready
  );
  modport sink (
    input  valid, later_year, later_month, later_day, later_hour, later_minute,
           later_second, earlier_year, earlier_month, earlier_day, earlier_hour,
           earlier_minute, earlier_second,
    output ready
  );
endinterface

interface cdd_out_if;
  logic               valid;
  logic               ready;
  logic signed [35:0] difference;
  logic               range_error;

  modport source (output valid, difference, range_error, input ready);
  modport sink (input valid, difference, range_error, output ready);
endinterface

/* hdl/cdd_alu.sv */
// Shared add/subtract unit used by every accumulator step of the sequencer.
module cdd_alu (
  input  logic signed [cdd_pkg::ACC_W-1:0] a_i,
  input  logic signed [cdd_pkg::ACC_W-1:0] b_i,
  input  logic                             sub_i,
  output logic signed [cdd_pkg::ACC_W-1:0] y_o
);

  assign y_o = sub_i ? (a_i - b_i) : (a_i + b_i);

endmodule

/* hdl/cdd_year_ctr.sv */
// Year walker from 1900 upward with running mod 4/100/400 counters for the leap test.
module cdd_year_ctr (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cdd_pkg::yc_ctrl_t            ctrl_i,
  output logic [cdd_pkg::YR_W-1:0]     yr_o,
  output logic                         leap_o
);

  logic [cdd_pkg::YR_W-1:0] yr_q, yr_d;
  logic [1:0]               m4_q, m4_d;
  logic [6:0]               m100_q, m100_d;
  logic [8:0]               m400_q, m400_d;

  always_comb begin
    yr_d   = yr_q;
    m4_d   = m4_q;
    m100_d = m100_q;
    m400_d = m400_q;
    if (ctrl_i.init) begin
      yr_d   = '0;
      m4_d   = 2'd0;
      m100_d = 7'd0;
      m400_d = cdd_pkg::BASE_MOD400;
    end else if (ctrl_i.step) begin
      yr_d   = yr_q + 1'b1;
      m4_d   = m4_q + 2'd1;
      m100_d = (m100_q == 7'd99) ? 7'd0 : m100_q + 7'd1;
      m400_d = (m400_q == 9'd399) ? 9'd0 : m400_q + 9'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      yr_q   <= '0;
      m4_q   <= 2'd0;
      m100_q <= 7'd0;
      m400_q <= cdd_pkg::BASE_MOD400;
    end else begin
      yr_q   <= yr_d;
      m4_q   <= m4_d;
      m100_q <= m100_d;
      m400_q <= m400_d;
    end
  end

  assign yr_o   = yr_q;
  assign leap_o = ((m4_q == 2'd0) && (m100_q != 7'd0)) || (m400_q == 9'd0);

endmodule

/* hdl/calendar_datetime_difference.sv */
// Top level: sequencer and datapath of the Gregorian date-time difference block.
//
// A request on in_req_i carries a later and an earlier broken-down date-time
// (year from 1900, month, day, hour, minute, second). The response on out_rsp_o
// gives later minus earlier in the unit set by register 0 (year .. second), as
// a 36-bit two's complement value saturated to +/-(2^35-1), and range_error
// for an invalid unit or a year span over the minute/second limit (difference
// is then 0). Registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i
// while no request is in flight; the user must keep to this, as the block
// itself does not enforce it. One request is worked at a time; ready is high
// only while idle. Year and month units skip the year walk and start from the
// year span. Day and finer units walk the years from 1900 up to the larger
// year, one year per cycle through the shared adder, then 4 to 13 more
// add/shift steps. Error requests go from idle straight to the done step.
// The result sits in an output register; a new request is taken while it waits,
// and the sequencer holds in its last step until the receiver frees it.
// Reset restores the register defaults (day unit, limits 1023 and 67) and
// empties the output register.
module calendar_datetime_difference (
  input  logic             clk_i,
  input  logic             rst_ni,
  cdd_in_if.sink           in_req_i,
  cdd_out_if.source        out_rsp_o,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [9:0]       cfg_wdata_i
);

  localparam int YW = cdd_pkg::YR_W;
  localparam int AW = cdd_pkg::ACC_W;

  // configuration
  logic [2:0]               unit_cfg_q;
  logic [cdd_pkg::LIM_W-1:0] min_lim_q, sec_lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      unit_cfg_q <= cdd_pkg::UNIT_DAY;
      min_lim_q  <= 10'd1023;
      sec_lim_q  <= 10'd67;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cdd_pkg::CFG_UNIT:    unit_cfg_q <= cfg_wdata_i[2:0];
        cdd_pkg::CFG_MIN_LIM: min_lim_q  <= cfg_wdata_i;
        cdd_pkg::CFG_SEC_LIM: sec_lim_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // request decode: order the pair, span and error
  logic [YW-1:0] a_yr, b_yr, hi_yr_d, lo_yr_d, yy_d;
  logic          neg_d, err_d;

  always_comb begin
    a_yr    = cdd_pkg::clamp_year(in_req_i.later_year);
    b_yr    = cdd_pkg::clamp_year(in_req_i.earlier_year);
    neg_d   = a_yr < b_yr;
    hi_yr_d = neg_d ? b_yr : a_yr;
    lo_yr_d = neg_d ? a_yr : b_yr;
    yy_d    = hi_yr_d - lo_yr_d;
    case (unit_cfg_q)
      cdd_pkg::UNIT_YEAR,
      cdd_pkg::UNIT_MONTH,
      cdd_pkg::UNIT_DAY,
      cdd_pkg::UNIT_HOUR:   err_d = 1'b0;
      cdd_pkg::UNIT_MINUTE: err_d = int'(yy_d) > int'(min_lim_q);
      cdd_pkg::UNIT_SECOND: err_d = int'(yy_d) > int'(sec_lim_q);
      default:              err_d = 1'b1;
    endcase
  end

  // working registers
  cdd_pkg::state_e state_q, state_d;
  logic [YW-1:0]   hi_yr_q, lo_yr_q, yy_q;
  logic [3:0]      hi_mo_q, lo_mo_q;
  logic [4:0]      hi_dy_q, lo_dy_q, hi_hr_q, lo_hr_q;
  logic [5:0]      hi_mi_q, lo_mi_q, hi_se_q, lo_se_q;
  logic            neg_q, err_q, leap_hi_q, leap_lo_q;
  logic [2:0]      unit_q;
  logic signed [AW-1:0] acc_q;

  // sequencer outputs
  logic                 ld_in, acc_clr, acc_we, cap_hi, cap_lo, out_ld;
  logic signed [AW-1:0] alu_a, alu_b, alu_y;
  logic                 alu_sub;
  cdd_pkg::yc_ctrl_t    yc;
  logic [YW-1:0]        yr;
  logic                 leap;

  cdd_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sub_i (alu_sub),
    .y_o   (alu_y)
  );

  cdd_year_ctr u_year (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (yc),
    .yr_o   (yr),
    .leap_o (leap)
  );

  logic out_valid_q;

  always_comb begin
    state_d = state_q;
    ld_in   = 1'b0;
    acc_clr = 1'b0;
    acc_we  = 1'b0;
    cap_hi  = 1'b0;
    cap_lo  = 1'b0;
    out_ld  = 1'b0;
    alu_a   = acc_q;
    alu_b   = '0;
    alu_sub = 1'b0;
    yc      = '0;
    case (state_q)
      cdd_pkg::ST_IDLE: begin
        if (in_req_i.valid) begin
          ld_in   = 1'b1;
          acc_clr = 1'b1;
          yc.init = 1'b1;
          if (err_d) begin
            state_d = cdd_pkg::ST_DONE;
          end else if (unit_cfg_q == cdd_pkg::UNIT_YEAR ||
                       unit_cfg_q == cdd_pkg::UNIT_MONTH) begin
            state_d = cdd_pkg::ST_YY;
          end else begin
            state_d = cdd_pkg::ST_YEARS;
          end
        end
      end
      cdd_pkg::ST_YEARS: begin
        cap_lo = (yr == lo_yr_q);
        if (yr == hi_yr_q) begin
          cap_hi  = 1'b1;
          state_d = cdd_pkg::ST_DOY_HI;
        end else begin
          yc.step = 1'b1;
          // count whole years from the earlier year on
          acc_we  = (yr >= lo_yr_q);
          alu_b   = AW'(cdd_pkg::DAYS_YEAR + 9'(leap));
        end
      end
      cdd_pkg::ST_DOY_HI: begin
        acc_we  = 1'b1;
        alu_b   = AW'(cdd_pkg::month_start(hi_mo_q, leap_hi_q));
        state_d = cdd_pkg::ST_DAY_HI;
      end
      cdd_pkg::ST_DAY_HI: begin
        acc_we  = 1'b1;
        alu_b   = AW'(hi_dy_q);
        state_d = cdd_pkg::ST_DOY_LO;
      end
      cdd_pkg::ST_DOY_LO: begin
        acc_we  = 1'b1;
        alu_sub = 1'b1;
        alu_b   = AW'(cdd_pkg::month_start(lo_mo_q, leap_lo_q));
        state_d = cdd_pkg::ST_DAY_LO;
      end
      cdd_pkg::ST_DAY_LO: begin
        acc_we  = 1'b1;
        alu_sub = 1'b1;
        alu_b   = AW'(lo_dy_q);
        state_d = (unit_q == cdd_pkg::UNIT_DAY) ? cdd_pkg::ST_NEG : cdd_pkg::ST_MUL24;
      end
      cdd_pkg::ST_YY: begin
        acc_we  = 1'b1;
        alu_b   = AW'(yy_q);
        state_d = (unit_q == cdd_pkg::UNIT_YEAR) ? cdd_pkg::ST_NEG : cdd_pkg::ST_MUL12;
      end
      cdd_pkg::ST_MUL12: begin
        acc_we  = 1'b1;
        alu_a   = acc_q <<< 3;
        alu_b   = acc_q <<< 2;
        state_d = cdd_pkg::ST_ADD_MO;
      end
      cdd_pkg::ST_ADD_MO: begin
        acc_we  = 1'b1;
        alu_b   = AW'(hi_mo_q);
        state_d = cdd_pkg::ST_SUB_MO;
      end
      cdd_pkg::ST_SUB_MO: begin
        acc_we  = 1'b1;
        alu_sub = 1'b1;
        alu_b   = AW'(lo_mo_q);
        state_d = cdd_pkg::ST_NEG;
      end
      cdd_pkg::ST_MUL24: begin
        acc_we  = 1'b1;
        alu_a   = acc_q <<< 4;
        alu_b   = acc_q <<< 3;
        state_d = cdd_pkg::ST_ADD_HR;
      end
      cdd_pkg::ST_ADD_HR: begin
        acc_we  = 1'b1;
        alu_b   = AW'(hi_hr_q);
        state_d = cdd_pkg::ST_SUB_HR;
      end
      cdd_pkg::ST_SUB_HR: begin
        acc_we  = 1'b1;
        alu_sub = 1'b1;
        alu_b   = AW'(lo_hr_q);
        state_d = (unit_q == cdd_pkg::UNIT_HOUR) ? cdd_pkg::ST_NEG : cdd_pkg::ST_MUL60_MI;
      end
      cdd_pkg::ST_MUL60_MI: begin
        acc_we  = 1'b1;
        alu_sub = 1'b1;
        alu_a   = acc_q <<< 6;
        alu_b   = acc_q <<< 2;
        state_d = cdd_pkg::ST_ADD_MI;
      end
      cdd_pkg::ST_ADD_MI: begin
        acc_we  = 1'b1;
        alu_b   = AW'(hi_mi_q);
        state_d = cdd_pkg::ST_SUB_MI;
      end
      cdd_pkg::ST_SUB_MI: begin
        acc_we  = 1'b1;
        alu_sub = 1'b1;
        alu_b   = AW'(lo_mi_q);
        state_d = (unit_q == cdd_pkg::UNIT_MINUTE) ? cdd_pkg::ST_NEG : cdd_pkg::ST_MUL60_SE;
      end
      cdd_pkg::ST_MUL60_SE: begin
        acc_we  = 1'b1;
        alu_sub = 1'b1;
        alu_a   = acc_q <<< 6;
        alu_b   = acc_q <<< 2;
        state_d = cdd_pkg::ST_ADD_SE;
      end
      cdd_pkg::ST_ADD_SE: begin
        acc_we  = 1'b1;
        alu_b   = AW'(hi_se_q);
        state_d = cdd_pkg::ST_SUB_SE;
      end
      cdd_pkg::ST_SUB_SE: begin
        acc_we  = 1'b1;
        alu_sub = 1'b1;
        alu_b   = AW'(lo_se_q);
        state_d = cdd_pkg::ST_NEG;
      end
      cdd_pkg::ST_NEG: begin
        // negate for a swapped pair, pass through otherwise
        acc_we  = 1'b1;
        alu_a   = '0;
        alu_b   = acc_q;
        alu_sub = neg_q;
        state_d = cdd_pkg::ST_DONE;
      end
      cdd_pkg::ST_DONE: begin
        if (!out_valid_q || out_rsp_o.ready) begin
          out_ld  = 1'b1;
          state_d = cdd_pkg::ST_IDLE;
        end
      end
      default: state_d = cdd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cdd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_in) begin
      neg_q   <= neg_d;
      err_q   <= err_d;
      unit_q  <= unit_cfg_q;
      yy_q    <= yy_d;
      hi_yr_q <= hi_yr_d;
      lo_yr_q <= lo_yr_d;
      hi_mo_q <= neg_d ? in_req_i.earlier_month  : in_req_i.later_month;
      lo_mo_q <= neg_d ? in_req_i.later_month    : in_req_i.earlier_month;
      hi_dy_q <= neg_d ? in_req_i.earlier_day    : in_req_i.later_day;
      lo_dy_q <= neg_d ? in_req_i.later_day      : in_req_i.earlier_day;
      hi_hr_q <= neg_d ? in_req_i.earlier_hour   : in_req_i.later_hour;
      lo_hr_q <= neg_d ? in_req_i.later_hour     : in_req_i.earlier_hour;
      hi_mi_q <= neg_d ? in_req_i.earlier_minute : in_req_i.later_minute;
      lo_mi_q <= neg_d ? in_req_i.later_minute   : in_req_i.earlier_minute;
      hi_se_q <= neg_d ? in_req_i.earlier_second : in_req_i.later_second;
      lo_se_q <= neg_d ? in_req_i.later_second   : in_req_i.earlier_second;
    end
    if (cap_hi) begin
      leap_hi_q <= leap;
    end
    if (cap_lo) begin
      leap_lo_q <= leap;
    end
    if (acc_clr) begin
      acc_q <= '0;
    end else if (acc_we) begin
      acc_q <= alu_y;
    end
  end

  // saturate and zero on error
  logic signed [AW-1:0] sat;

  always_comb begin
    if (err_q) begin
      sat = '0;
    end else if (acc_q > cdd_pkg::DIFF_MAX) begin
      sat = cdd_pkg::DIFF_MAX;
    end else if (acc_q < cdd_pkg::DIFF_MIN) begin
      sat = cdd_pkg::DIFF_MIN;
    end else begin
      sat = acc_q;
    end
  end

  logic signed [cdd_pkg::DIFF_W-1:0] out_diff_q;
  logic                              out_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ld) begin
      out_diff_q <= sat[cdd_pkg::DIFF_W-1:0];
      out_err_q  <= err_q;
    end
  end

  assign in_req_i.ready        = (state_q == cdd_pkg::ST_IDLE);
  assign out_rsp_o.valid       = out_valid_q;
  assign out_rsp_o.difference  = out_diff_q;
  assign out_rsp_o.range_error = out_err_q;

endmodule
